// File: rtl/sfa_pkg.sv
// ----------------------------------------------------------------------------
// sfa_pkg
// Shared types and constants for the screen fade alpha controller.
// ----------------------------------------------------------------------------
package sfa_pkg;

    localparam int FIELD_BITS = 16;
    localparam int QUOT_BITS  = 8;

    localparam logic [7:0] ALPHA_FULL = 8'hFF;

    typedef enum logic [1:0] {
        MODE_OPAQUE   = 2'd0,
        MODE_CLEAR    = 2'd1,
        MODE_FADE_IN  = 2'd2,
        MODE_FADE_OUT = 2'd3
    } mode_t;

    typedef enum logic [1:0] {
        REQ_TICK       = 2'd0,
        REQ_FADE_IN    = 2'd1,
        REQ_FADE_OUT   = 2'd2,
        REQ_SET_STATUS = 2'd3
    } req_t;

    typedef enum logic [1:0] {
        SEQ_IDLE,
        SEQ_CALC,
        SEQ_DONE
    } seq_state_t;

    typedef enum logic [1:0] {
        DIV_IDLE,
        DIV_PREP,
        DIV_STEP
    } div_state_t;

    typedef struct packed {
        logic busy;
        logic done;
    } div_stat_t;

endpackage

// File: rtl/sfa_if.sv
// ----------------------------------------------------------------------------
// sfa_req_if / sfa_rsp_if
// Valid/ready channels for fade requests and fade results.
// ----------------------------------------------------------------------------
interface sfa_req_if;
    logic        valid;
    logic        ready;
    logic [1:0]  req_type;
    logic [15:0] fade_length;
    logic        target_state;
    logic [15:0] delay_ticks;

    modport source (
        output valid, req_type, fade_length, target_state, delay_ticks,
        input  ready
    );
    modport sink (
        input  valid, req_type, fade_length, target_state, delay_ticks,
        output ready
    );
endinterface

interface sfa_rsp_if;
    logic       valid;
    logic       ready;
    logic [7:0] alpha;
    logic [1:0] fade_state;
    logic       accepted;

    modport source (
        output valid, alpha, fade_state, accepted,
        input  ready
    );
    modport sink (
        input  valid, alpha, fade_state, accepted,
        output ready
    );
endinterface

// File: rtl/sfa_div.sv
// ----------------------------------------------------------------------------
// sfa_div
// Iterative ramp divider: quotient of count*255 / length, one bit per cycle.
// ----------------------------------------------------------------------------
module sfa_div #(
    parameter int CNT_W = 16
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            start,
    input  logic [CNT_W-1:0]                count,
    input  logic [CNT_W-1:0]                length,
    output logic [sfa_pkg::QUOT_BITS-1:0]   quot,
    output sfa_pkg::div_stat_t              stat
);
    import sfa_pkg::*;

    localparam int W      = CNT_W + QUOT_BITS;
    localparam int STEP_W = $clog2(QUOT_BITS);

    div_state_t              state_reg, state_next;
    logic [STEP_W-1:0]       step_reg, step_next;
    logic [W-1:0]            rem_reg, rem_next;
    logic [W-1:0]            dsh_reg, dsh_next;
    logic [CNT_W-1:0]        len_reg, len_next;
    logic [QUOT_BITS-1:0]    quot_reg, quot_next;
    logic                    done_reg, done_next;

    // The one subtractor, shared by the product step and every quotient bit.
    logic [W:0]              diff;
    logic                    borrow;

    assign diff   = {1'b0, rem_reg} - {1'b0, dsh_reg};
    assign borrow = diff[W];

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            DIV_IDLE: if (start) state_next = DIV_PREP;
            DIV_PREP: state_next = DIV_STEP;
            DIV_STEP: if (step_reg == '0) state_next = DIV_IDLE;
            default:  state_next = DIV_IDLE;
        endcase
    end

    always_comb
    begin
        step_next = step_reg;
        rem_next  = rem_reg;
        dsh_next  = dsh_reg;
        len_next  = len_reg;
        quot_next = quot_reg;
        done_next = 1'b0;
        unique case (state_reg)
            DIV_IDLE:
            begin
                if (start)
                begin
                    // count*255 is formed as (count << 8) - count.
                    rem_next = {count, {QUOT_BITS{1'b0}}};
                    dsh_next = {{QUOT_BITS{1'b0}}, count};
                    len_next = length;
                end
            end
            DIV_PREP:
            begin
                rem_next  = diff[W-1:0];
                dsh_next  = {1'b0, len_reg, {(QUOT_BITS-1){1'b0}}};
                step_next = STEP_W'(QUOT_BITS - 1);
            end
            DIV_STEP:
            begin
                if (!borrow)
                    rem_next = diff[W-1:0];
                quot_next = {quot_reg[QUOT_BITS-2:0], ~borrow};
                dsh_next  = dsh_reg >> 1;
                step_next = step_reg - 1'b1;
                if (step_reg == '0)
                    done_next = 1'b1;
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= DIV_IDLE;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        step_reg <= step_next;
        rem_reg  <= rem_next;
        dsh_reg  <= dsh_next;
        len_reg  <= len_next;
        quot_reg <= quot_next;
    end

    assign quot      = quot_reg;
    assign stat.busy = (state_reg != DIV_IDLE);
    assign stat.done = done_reg;

`ifndef SYNTH
    a_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
        start |-> state_reg == DIV_IDLE)
        else $error("divider started while busy");

    a_done_after_step: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> $past(state_reg == DIV_STEP) && state_reg == DIV_IDLE)
        else $error("divider done without a final step");

    a_done_pulse: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |=> !done_reg)
        else $error("divider done held longer than one cycle");
`endif

endmodule

// File: rtl/screen_fade_alpha_controller.sv
// ----------------------------------------------------------------------------
// screen_fade_alpha_controller
// Overlay fade controller: opaque, clear, fade in and fade out, with alpha.
// ----------------------------------------------------------------------------
//  Channel  Dir  Payload                                          Handshake
//  req      in   req_type, fade_length, target_state, delay_ticks valid/ready
//  rsp      out  alpha, fade_state, accepted                      valid/ready
//
//  A frame tick during a fade starts the divider, which loads on the accepting
//  edge. A prep step forms count*255, and the shared subtractor of sfa_div
//  then produces the quotient bit by bit. Alpha is written from the quotient
//  once the divider signals done, and the result then moves into the output
//  register. Every other transaction goes from acceptance to the done state
//  and, once the output is free, into the output register. A new request is
//  taken once the previous result has moved into the output register.
//  Reset is asynchronous, active low; no clearing pass is needed.
//  A stalled rsp holds its result; the next result waits behind it.
// ----------------------------------------------------------------------------
module screen_fade_alpha_controller #(
    parameter int COUNT_BITS = 16
) (
    input  logic       clk,
    input  logic       rst_n,
    sfa_req_if.sink    req,
    sfa_rsp_if.source  rsp
);
    import sfa_pkg::*;

    localparam int EXT_W = (COUNT_BITS > FIELD_BITS) ? COUNT_BITS : FIELD_BITS;

    seq_state_t              state_reg, state_next;
    mode_t                   mode_reg, mode_next;
    logic [7:0]              alpha_reg, alpha_next;
    logic [COUNT_BITS-1:0]   ramp_count_reg, ramp_count_next;
    logic [COUNT_BITS-1:0]   ramp_length_reg, ramp_length_next;
    mode_t                   pending_mode_reg, pending_mode_next;
    logic                    pending_valid_reg, pending_valid_next;
    logic [COUNT_BITS-1:0]   pending_count_reg, pending_count_next;
    logic                    fade_in_reg, fade_in_next;
    logic                    acc_reg, acc_next;

    logic                    out_valid_reg, out_valid_next;
    logic [7:0]              out_alpha_reg, out_alpha_next;
    logic [1:0]              out_state_reg, out_state_next;
    logic                    out_acc_reg, out_acc_next;

    logic                    in_fire;
    logic                    out_free;
    logic                    need_div;
    logic [EXT_W-1:0]        len_ext, dly_ext;
    logic [COUNT_BITS-1:0]   len_c, dly_c;
    logic [COUNT_BITS-1:0]   count_inc;
    mode_t                   tick_mode;

    logic [QUOT_BITS-1:0]    quot;
    div_stat_t               div_stat;

    assign in_fire  = req.valid && req.ready;
    assign out_free = !out_valid_reg || rsp.ready;

    assign len_ext = EXT_W'(req.fade_length);
    assign dly_ext = EXT_W'(req.delay_ticks);
    assign len_c   = len_ext[COUNT_BITS-1:0];
    assign dly_c   = dly_ext[COUNT_BITS-1:0];

    assign count_inc = (ramp_count_reg < ramp_length_reg) ?
                       ramp_count_reg + 1'b1 : ramp_count_reg;

    // A pending change whose delay has run out takes effect before alpha.
    assign tick_mode = (pending_valid_reg && pending_count_reg == '0) ?
                       pending_mode_reg : mode_reg;

    sfa_div #(
        .CNT_W (COUNT_BITS)
    ) u_div (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (need_div),
        .count  (count_inc),
        .length (ramp_length_reg),
        .quot   (quot),
        .stat   (div_stat)
    );

    // Sequencer: next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            SEQ_IDLE: if (in_fire) state_next = need_div ? SEQ_CALC : SEQ_DONE;
            SEQ_CALC: if (div_stat.done) state_next = SEQ_DONE;
            SEQ_DONE: if (out_free) state_next = SEQ_IDLE;
            default:  state_next = SEQ_IDLE;
        endcase
    end

    // Sequencer: outputs
    always_comb
    begin
        req.ready = (state_reg == SEQ_IDLE);
    end

    // Fade state update
    always_comb
    begin
        mode_next          = mode_reg;
        alpha_next         = alpha_reg;
        ramp_count_next    = ramp_count_reg;
        ramp_length_next   = ramp_length_reg;
        pending_mode_next  = pending_mode_reg;
        pending_valid_next = pending_valid_reg;
        pending_count_next = pending_count_reg;
        fade_in_next       = fade_in_reg;
        acc_next           = acc_reg;
        need_div           = 1'b0;

        if (in_fire)
        begin
            acc_next = 1'b0;
            unique case (req_t'(req.req_type))
                REQ_TICK:
                begin
                    if (pending_valid_reg)
                    begin
                        if (pending_count_reg == '0)
                            pending_valid_next = 1'b0;
                        else
                            pending_count_next = pending_count_reg - 1'b1;
                    end
                    mode_next = tick_mode;
                    unique case (tick_mode) inside
                        MODE_OPAQUE: alpha_next = ALPHA_FULL;
                        MODE_CLEAR:  ;
                        MODE_FADE_IN, MODE_FADE_OUT:
                        begin
                            // A zero-length fade ends at once with alpha kept.
                            if (ramp_length_reg == '0)
                            begin
                                mode_next = (tick_mode == MODE_FADE_IN) ?
                                            MODE_CLEAR : MODE_OPAQUE;
                            end
                            else
                            begin
                                ramp_count_next = count_inc;
                                need_div        = 1'b1;
                                fade_in_next    = (tick_mode == MODE_FADE_IN);
                                if (count_inc >= ramp_length_reg)
                                    mode_next = (tick_mode == MODE_FADE_IN) ?
                                                MODE_CLEAR : MODE_OPAQUE;
                            end
                        end
                        default: ;
                    endcase
                end
                REQ_FADE_IN:
                begin
                    if (mode_reg == MODE_OPAQUE)
                    begin
                        mode_next        = MODE_FADE_IN;
                        ramp_count_next  = '0;
                        ramp_length_next = len_c;
                        acc_next         = 1'b1;
                    end
                end
                REQ_FADE_OUT:
                begin
                    if (mode_reg == MODE_CLEAR)
                    begin
                        mode_next        = MODE_FADE_OUT;
                        ramp_count_next  = '0;
                        ramp_length_next = len_c;
                        acc_next         = 1'b1;
                    end
                end
                REQ_SET_STATUS:
                begin
                    pending_mode_next  = mode_t'({1'b0, req.target_state});
                    pending_valid_next = 1'b1;
                    if (dly_c != '0)
                        pending_count_next = dly_c;
                    else
                    begin
                        mode_next          = mode_t'({1'b0, req.target_state});
                        pending_count_next = '0;
                    end
                end
                default: ;
            endcase
        end
        else if (state_reg == SEQ_CALC && div_stat.done)
        begin
            alpha_next = fade_in_reg ? ALPHA_FULL - quot : quot;
        end
    end

    // Output register
    always_comb
    begin
        out_valid_next = out_valid_reg;
        out_alpha_next = out_alpha_reg;
        out_state_next = out_state_reg;
        out_acc_next   = out_acc_reg;
        if (rsp.ready)
            out_valid_next = 1'b0;
        if (state_reg == SEQ_DONE && out_free)
        begin
            out_valid_next = 1'b1;
            out_alpha_next = alpha_reg;
            out_state_next = mode_reg;
            out_acc_next   = acc_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg         <= SEQ_IDLE;
            mode_reg          <= MODE_OPAQUE;
            alpha_reg         <= ALPHA_FULL;
            ramp_count_reg    <= '0;
            ramp_length_reg   <= '0;
            pending_mode_reg  <= MODE_OPAQUE;
            pending_valid_reg <= 1'b0;
            pending_count_reg <= '0;
            out_valid_reg     <= 1'b0;
        end
        else
        begin
            state_reg         <= state_next;
            mode_reg          <= mode_next;
            alpha_reg         <= alpha_next;
            ramp_count_reg    <= ramp_count_next;
            ramp_length_reg   <= ramp_length_next;
            pending_mode_reg  <= pending_mode_next;
            pending_valid_reg <= pending_valid_next;
            pending_count_reg <= pending_count_next;
            out_valid_reg     <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        fade_in_reg   <= fade_in_next;
        acc_reg       <= acc_next;
        out_alpha_reg <= out_alpha_next;
        out_state_reg <= out_state_next;
        out_acc_reg   <= out_acc_next;
    end

    assign rsp.valid      = out_valid_reg;
    assign rsp.alpha      = out_alpha_reg;
    assign rsp.fade_state = out_state_reg;
    assign rsp.accepted   = out_acc_reg;

`ifndef SYNTH
    a_count_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        ramp_count_reg <= ramp_length_reg)
        else $error("ramp count ran past the fade length");

    a_div_only_in_calc: assert property (@(posedge clk) disable iff (!rst_n)
        div_stat.done |-> state_reg == SEQ_CALC)
        else $error("divider result arrived outside the calculation phase");

    a_calc_has_div: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == SEQ_CALC |-> div_stat.busy || div_stat.done)
        else $error("waiting for a divider that is not running");
`endif

endmodule

// File: tb/sfa_fade_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// sfa_fade_checker
// Watches the request and result channels of the fade controller. For every
// accepted request it computes the alpha, state and accepted flag the block
// must return, and compares each accepted result with the oldest one pending.
// ----------------------------------------------------------------------------
module sfa_fade_checker #(
    parameter int COUNT_BITS = 16
) (
    input  logic clk,
    input  logic rst_n,
    sfa_req_if   req_mon,
    sfa_rsp_if   rsp_mon,
    output int   mismatches,
    output int   results_owed
);
    import sfa_pkg::*;

    typedef struct packed {
        logic [7:0] alpha;
        mode_t      state;
        logic       accepted;
    } fade_result_t;

    fade_result_t fade_results_q[$];

    mode_t                 cur_mode;
    mode_t                 pend_mode;
    logic                  pend_valid;
    logic [7:0]            alpha_q;
    logic [COUNT_BITS-1:0] ramp_cnt;
    logic [COUNT_BITS-1:0] ramp_len;
    logic [COUNT_BITS-1:0] pend_cnt;

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("%0t ns: %s mismatch, got %0d, want %0d", $realtime, what, got, want);
        mismatches++;
    endtask

    // Position along the ramp scaled to 0..255; the product never wraps.
    function automatic logic [7:0] ramp_share();
        logic [COUNT_BITS+7:0] scaled;
        logic [COUNT_BITS+7:0] quot;
        scaled = {8'd0, ramp_cnt} * ALPHA_FULL;
        quot   = scaled / {8'd0, ramp_len};
        return quot[7:0];
    endfunction

    task automatic frame_tick();
        mode_t end_mode;
        if (pend_valid)
        begin
            if (pend_cnt == '0)
            begin
                cur_mode   = pend_mode;
                pend_valid = 1'b0;
            end
            else
            begin
                pend_cnt = pend_cnt - 1'b1;
            end
        end
        case (cur_mode)
            MODE_OPAQUE: alpha_q = ALPHA_FULL;
            MODE_CLEAR:  ;
            default:
            begin
                end_mode = (cur_mode == MODE_FADE_IN) ? MODE_CLEAR : MODE_OPAQUE;
                // A zero-length fade ends at once and leaves alpha alone.
                if (ramp_len == '0)
                begin
                    cur_mode = end_mode;
                end
                else
                begin
                    if (ramp_cnt < ramp_len)
                        ramp_cnt = ramp_cnt + 1'b1;
                    alpha_q = (cur_mode == MODE_FADE_IN) ? ALPHA_FULL - ramp_share()
                                                         : ramp_share();
                    if (ramp_cnt >= ramp_len)
                        cur_mode = end_mode;
                end
            end
        endcase
    endtask

    task automatic apply_request(input req_t kind, input logic [15:0] len,
                                 input logic tgt, input logic [15:0] dly,
                                 output fade_result_t res);
        mode_t needed;
        res.accepted = 1'b0;
        case (kind) inside
            REQ_TICK: frame_tick();
            REQ_FADE_IN, REQ_FADE_OUT:
            begin
                needed = (kind == REQ_FADE_IN) ? MODE_OPAQUE : MODE_CLEAR;
                if (cur_mode == needed)
                begin
                    cur_mode     = (kind == REQ_FADE_IN) ? MODE_FADE_IN : MODE_FADE_OUT;
                    ramp_cnt     = '0;
                    ramp_len     = COUNT_BITS'(len);
                    res.accepted = 1'b1;
                end
            end
            default:
            begin
                // An immediate change still leaves a pending change armed, so
                // the next tick applies the same target again.
                pend_mode  = mode_t'({1'b0, tgt});
                pend_valid = 1'b1;
                if (COUNT_BITS'(dly) != '0)
                begin
                    pend_cnt = COUNT_BITS'(dly);
                end
                else
                begin
                    cur_mode = pend_mode;
                    pend_cnt = '0;
                end
            end
        endcase
        res.alpha = alpha_q;
        res.state = cur_mode;
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        fade_result_t want;
        fade_result_t got;
        if (!rst_n)
        begin
            cur_mode     = MODE_OPAQUE;
            pend_mode    = MODE_OPAQUE;
            pend_valid   = 1'b0;
            alpha_q      = ALPHA_FULL;
            ramp_cnt     = '0;
            ramp_len     = '0;
            pend_cnt     = '0;
            mismatches   = 0;
            results_owed = 0;
            fade_results_q.delete();
        end
        else
        begin
            if (req_mon.valid && req_mon.ready)
            begin
                apply_request(req_t'(req_mon.req_type), req_mon.fade_length,
                              req_mon.target_state, req_mon.delay_ticks, want);
                fade_results_q.push_back(want);
            end
            if (rsp_mon.valid && rsp_mon.ready)
            begin
                got.alpha    = rsp_mon.alpha;
                got.state    = mode_t'(rsp_mon.fade_state);
                got.accepted = rsp_mon.accepted;
                if (fade_results_q.size() == 0)
                begin
                    report_mismatch("unexpected result, alpha", got.alpha, -1);
                end
                else
                begin
                    want = fade_results_q.pop_front();
                    if (got.alpha !== want.alpha)
                        report_mismatch("alpha", got.alpha, want.alpha);
                    if (got.state !== want.state)
                        report_mismatch("fade_state", got.state, want.state);
                    if (got.accepted !== want.accepted)
                        report_mismatch("accepted", got.accepted, want.accepted);
                end
            end
            results_owed = fade_results_q.size();
        end
    end

endmodule

// File: tb/tb_screen_fade_alpha_controller.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_screen_fade_alpha_controller
// Drives fade requests into the controller and drains its results with
// random idle and stall bursts, a long result hold-off, and a checker that
// predicts every result. Directed corner cases come first, then well-formed
// fade and status sequences mixed with random requests.
// ----------------------------------------------------------------------------
module tb_screen_fade_alpha_controller;
    import sfa_pkg::*;

    localparam int TOTAL_ITEMS = 1050;
    localparam int QUIET_FROM  = 880;
    localparam int HOLD_AT     = 300;
    localparam int HOLD_CYCLES = 300;
    localparam int TAIL_CYCLES = 40;
    localparam int CYCLE_LIMIT = 200000;

    logic clk = 1'b0;
    logic rst_n;
    int   items_sent = 0;
    bit   idle_en = 1'b1;
    int   cycles = 0;
    int   mismatches;
    int   results_owed;

    sfa_req_if req_ch ();
    sfa_rsp_if rsp_ch ();

    screen_fade_alpha_controller DUT (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .rsp   (rsp_ch)
    );

    sfa_fade_checker u_checker (
        .clk          (clk),
        .rst_n        (rst_n),
        .req_mon      (req_ch),
        .rsp_mon      (rsp_ch),
        .mismatches   (mismatches),
        .results_owed (results_owed)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("tb_screen_fade_alpha_controller: done, errors");
            $finish;
        end
    end

    task automatic send_req(input req_t kind, input logic [15:0] len,
                            input logic tgt, input logic [15:0] dly);
        int gap;
        if (idle_en && $urandom_range(0, 3) == 0)
        begin
            gap = $urandom_range(1, 6);
            req_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req_ch.valid        <= 1'b1;
        req_ch.req_type     <= kind;
        req_ch.fade_length  <= len;
        req_ch.target_state <= tgt;
        req_ch.delay_ticks  <= dly;
        @(posedge clk);
        while (!req_ch.ready) @(posedge clk);
        items_sent++;
    endtask

    // Unused fields of a tick still carry random bits.
    task automatic send_tick();
        send_req(REQ_TICK, 16'($urandom), 1'($urandom_range(0, 1)), 16'($urandom));
    endtask

    function automatic logic [15:0] mixed_value();
        int pick;
        pick = $urandom_range(0, 9);
        if (pick < 4)
            return 16'($urandom_range(0, 8));
        else if (pick == 4)
            return 16'd0;
        else if (pick == 5)
            return 16'hFFFF;
        else
            return 16'($urandom);
    endfunction

    task automatic send_noise();
        send_req(req_t'($urandom_range(0, 3)), mixed_value(),
                 1'($urandom_range(0, 1)), mixed_value());
    endtask

    initial
    begin : rsp_drain
        int gap;
        bit held;
        held = 1'b0;
        rsp_ch.ready <= 1'b0;
        @(posedge clk);
        while (!rst_n) @(posedge clk);
        forever
        begin
            if (!held && items_sent >= HOLD_AT)
            begin
                // Long hold-off: the sender keeps offering, so the block fills
                // up and has to stall its request channel.
                held = 1'b1;
                rsp_ch.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
            end
            else if (idle_en && $urandom_range(0, 3) == 0)
            begin
                gap = $urandom_range(1, 6);
                rsp_ch.ready <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            else
            begin
                rsp_ch.ready <= 1'b1;
                @(posedge clk);
            end
        end
    end

    initial
    begin : stimulus
        int          pick;
        int          n_ticks;
        bit          going_in;
        logic [15:0] len;
        logic [15:0] dly;
        rst_n               <= 1'b0;
        req_ch.valid        <= 1'b0;
        req_ch.req_type     <= REQ_TICK;
        req_ch.fade_length  <= '0;
        req_ch.target_state <= 1'b0;
        req_ch.delay_ticks  <= '0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed corner cases.
        send_req(REQ_TICK, 16'd0, 1'b0, 16'd0);
        send_req(REQ_FADE_OUT, 16'd5, 1'b0, 16'd0);        // wrong mode
        send_req(REQ_FADE_IN, 16'd0, 1'b0, 16'd0);         // zero-length fade
        send_tick();
        send_req(REQ_FADE_IN, 16'd4, 1'b1, 16'hFFFF);      // wrong mode
        send_req(REQ_FADE_OUT, 16'd3, 1'b0, 16'd0);
        repeat (3) send_tick();
        send_req(REQ_FADE_IN, 16'hFFFF, 1'b0, 16'd0);      // longest fade
        send_tick();
        send_req(REQ_SET_STATUS, 16'hFFFF, 1'b1, 16'd0);   // immediate clear
        send_req(REQ_FADE_OUT, 16'd2, 1'b0, 16'd0);
        send_tick();                                       // armed change wins
        send_req(REQ_SET_STATUS, 16'd0, 1'b0, 16'd2);
        repeat (3) send_tick();
        send_req(REQ_SET_STATUS, 16'd0, 1'b0, 16'hFFFF);
        send_req(REQ_SET_STATUS, 16'd0, 1'b1, 16'd1);      // replaces the long delay
        repeat (2) send_tick();
        send_req(REQ_FADE_OUT, 16'd1, 1'b0, 16'd0);
        send_req(REQ_TICK, 16'hFFFF, 1'b1, 16'hFFFF);

        while (items_sent < TOTAL_ITEMS)
        begin
            idle_en = (items_sent < QUIET_FROM) && (((items_sent / 150) % 3) != 2);
            pick = $urandom_range(0, 99);
            if (pick < 55)
            begin
                // Set the start mode, then run a fade; long fades are cut short.
                going_in = 1'($urandom_range(0, 1));
                send_req(REQ_SET_STATUS, 16'($urandom), going_in ? 1'b0 : 1'b1, 16'd0);
                if ($urandom_range(0, 7) != 0)
                    send_tick();
                len = ($urandom_range(0, 19) == 0) ? mixed_value()
                                                   : 16'($urandom_range(0, 12));
                send_req(going_in ? REQ_FADE_IN : REQ_FADE_OUT, len,
                         1'($urandom_range(0, 1)), 16'($urandom));
                n_ticks = ((len > 16'd20) ? 20 : int'(len)) + $urandom_range(0, 3);
                repeat (n_ticks)
                begin
                    if ($urandom_range(0, 9) == 0)
                        send_noise();
                    else
                        send_tick();
                end
            end
            else if (pick < 75)
            begin
                dly = 16'($urandom_range(0, 6));
                send_req(REQ_SET_STATUS, 16'($urandom), 1'($urandom_range(0, 1)), dly);
                n_ticks = int'(dly) + $urandom_range(1, 3);
                repeat (n_ticks) send_tick();
            end
            else
            begin
                repeat ($urandom_range(1, 4)) send_noise();
            end
        end
        req_ch.valid <= 1'b0;

        @(posedge clk);
        while (results_owed != 0) @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);
        if (mismatches == 0)
            $display("tb_screen_fade_alpha_controller: done, clean");
        else
            $display("tb_screen_fade_alpha_controller: done, errors");
        $finish;
    end

endmodule

// File: screen_fade_alpha_controller.f
rtl/sfa_pkg.sv
rtl/sfa_if.sv
rtl/sfa_div.sv
rtl/screen_fade_alpha_controller.sv
tb/sfa_fade_checker.sv
tb/tb_screen_fade_alpha_controller.sv
